FILE: sv/bbe_pkg.sv
// ----------------------------------------------------------------------------
// bbe_pkg
// shared types and constants of the 3x3 edge-normalized box blur
// ----------------------------------------------------------------------------
`default_nettype none

package bbe_pkg;

    localparam int CHAN_W       = 8;
    localparam int PIXEL_W      = 3 * CHAN_W;
    localparam int CFG_DATA_W   = 32;
    localparam int REG_IDX_W    = 1;
    localparam int CFG_ADDR_W   = REG_IDX_W + 2;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd1024;

    typedef logic [PIXEL_W-1:0] t_pixel;

    typedef struct packed {
        logic [WIDTH_REG_W-1:0]  width;
        logic [HEIGHT_REG_W-1:0] height;
        logic                    clear;
    } t_cfg;

    typedef struct packed {
        t_pixel     pix;
        logic       primed;
        logic [2:0] use_row;
        logic [2:0] use_col;
        logic       eof;
    } t_op;

endpackage

`default_nettype wire

FILE: sv/bbe_pix_if.sv
// ----------------------------------------------------------------------------
// bbe_pix_if
// input pixel channel: valid/ready handshake with action and rgb payload
// ----------------------------------------------------------------------------
`default_nettype none

interface bbe_pix_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;

    modport source (output valid, output action, output in_red, output in_green,
                    output in_blue, input ready);
    modport sink   (input valid, input action, input in_red, input in_green,
                    input in_blue, output ready);
endinterface

`default_nettype wire

FILE: sv/bbe_blur_if.sv
// ----------------------------------------------------------------------------
// bbe_blur_if
// output channel: valid/ready handshake with blurred rgb and end of frame
// ----------------------------------------------------------------------------
`default_nettype none

interface bbe_blur_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       end_of_frame;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output end_of_frame, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input end_of_frame, output ready);
endinterface

`default_nettype wire

FILE: sv/bbe_regs.sv
// ----------------------------------------------------------------------------
// bbe_regs
// apb register file holding image width and height
// ----------------------------------------------------------------------------
`default_nettype none

module bbe_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bbe_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [bbe_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [bbe_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    output bbe_pkg::t_cfg                    o_cfg
);

    logic [bbe_pkg::WIDTH_REG_W-1:0]  r_width;
    logic [bbe_pkg::HEIGHT_REG_W-1:0] r_height;
    logic [bbe_pkg::REG_IDX_W-1:0]    reg_idx;
    logic                             wr_en;

    assign reg_idx = paddr[bbe_pkg::CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= bbe_pkg::WIDTH_RESET;
            r_height <= bbe_pkg::HEIGHT_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                bbe_pkg::REG_IMAGE_WIDTH: begin
                    r_width <= pwdata[bbe_pkg::WIDTH_REG_W-1:0];
                end
                bbe_pkg::REG_IMAGE_HEIGHT: begin
                    r_height <= pwdata[bbe_pkg::HEIGHT_REG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            bbe_pkg::REG_IMAGE_WIDTH:  prdata = bbe_pkg::CFG_DATA_W'(r_width);
            bbe_pkg::REG_IMAGE_HEIGHT: prdata = bbe_pkg::CFG_DATA_W'(r_height);
            default:                   prdata = '0;
        endcase
    end

    // any write abandons the frame in progress
    assign o_cfg.width  = r_width;
    assign o_cfg.height = r_height;
    assign o_cfg.clear  = wr_en;

endmodule

`default_nettype wire

FILE: sv/bbe_front.sv
// ----------------------------------------------------------------------------
// bbe_front
// accepts pixels, tracks input and output raster positions, classifies each
// word (dropped, priming, producing) and builds its edge masks
// ----------------------------------------------------------------------------
`default_nettype none

module bbe_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bbe_pkg::t_cfg               i_cfg,
    bbe_pix_if.sink                     i_pix,
    input  logic                        i_push_ready,
    output logic                        o_push,
    output bbe_pkg::t_op                o_push_op,
    output logic [$clog2(MAX_WIDTH)-1:0] o_push_col
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int EW_W   = $clog2(MAX_WIDTH + 1);
    localparam int EH_W   = $clog2(MAX_HEIGHT + 1);
    localparam int IROW_W = $clog2(MAX_HEIGHT + 2);
    localparam int OROW_W = $clog2(MAX_HEIGHT);

    logic [IROW_W-1:0] r_in_row,  n_in_row;
    logic [COL_W-1:0]  r_in_col,  n_in_col;
    logic [OROW_W-1:0] r_out_row, n_out_row;
    logic [COL_W-1:0]  r_out_col, n_out_col;

    logic [EW_W-1:0] eff_w;
    logic [EH_W-1:0] eff_h;
    logic            accept;
    logic            drop;
    logic            primed;
    logic            in_col_last;
    logic            out_col_last;
    logic            out_row_last;

    always_comb begin
        if (i_cfg.width == '0) begin
            eff_w = EW_W'(1);
        end else if (32'(i_cfg.width) > MAX_WIDTH) begin
            eff_w = EW_W'(MAX_WIDTH);
        end else begin
            eff_w = EW_W'(i_cfg.width);
        end
        if (i_cfg.height == '0) begin
            eff_h = EH_W'(1);
        end else if (32'(i_cfg.height) > MAX_HEIGHT) begin
            eff_h = EH_W'(MAX_HEIGHT);
        end else begin
            eff_h = EH_W'(i_cfg.height);
        end
    end

    assign i_pix.ready = i_push_ready;
    assign accept      = i_pix.valid && i_push_ready;
    assign drop        = i_pix.action && (r_in_row == '0) && (r_in_col == '0);
    assign primed      = (r_in_row >= IROW_W'(2)) ||
                         ((r_in_row == IROW_W'(1)) && (r_in_col != '0));

    assign in_col_last  = (32'(r_in_col) + 32'd1) >= 32'(eff_w);
    assign out_col_last = (32'(r_out_col) + 32'd1) >= 32'(eff_w);
    assign out_row_last = (32'(r_out_row) + 32'd1) >= 32'(eff_h);

    always_comb begin
        o_push_op.pix        = i_pix.action ? '0 : {i_pix.in_red, i_pix.in_green, i_pix.in_blue};
        o_push_op.primed     = primed;
        o_push_op.use_row[0] = r_out_row != '0;
        o_push_op.use_row[1] = 1'b1;
        o_push_op.use_row[2] = !out_row_last;
        o_push_op.use_col[0] = r_out_col != '0;
        o_push_op.use_col[1] = 1'b1;
        o_push_op.use_col[2] = !out_col_last;
        o_push_op.eof        = primed && out_row_last && out_col_last;
    end

    assign o_push     = accept && !drop;
    assign o_push_col = r_in_col;

    always_comb begin
        n_in_row  = r_in_row;
        n_in_col  = r_in_col;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        if (i_cfg.clear) begin
            n_in_row  = '0;
            n_in_col  = '0;
            n_out_row = '0;
            n_out_col = '0;
        end else if (accept && !drop) begin
            if (in_col_last) begin
                n_in_col = '0;
                n_in_row = r_in_row + IROW_W'(1);
            end else begin
                n_in_col = r_in_col + COL_W'(1);
            end
            if (primed) begin
                if (out_row_last && out_col_last) begin
                    n_in_row  = '0;
                    n_in_col  = '0;
                    n_out_row = '0;
                    n_out_col = '0;
                end else if (out_col_last) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + OROW_W'(1);
                end else begin
                    n_out_col = r_out_col + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
        end else begin
            r_in_row  <= n_in_row;
            r_in_col  <= n_in_col;
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
        end
    end

endmodule

`default_nettype wire

FILE: sv/bbe_queue.sv
// ----------------------------------------------------------------------------
// bbe_queue
// small fifo of classified words between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module bbe_queue #(
    parameter int COL_W = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bbe_pkg::t_op     i_push_op,
    input  logic [COL_W-1:0] i_push_col,
    output logic             o_push_ready,
    input  logic             i_pop,
    output logic             o_head_valid,
    output bbe_pkg::t_op     o_head_op,
    output logic [COL_W-1:0] o_head_col
);

    localparam int DEPTH = bbe_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bbe_pkg::t_op     r_op  [DEPTH];
    logic [COL_W-1:0] r_col [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_push_ready = r_count != CNT_W'(DEPTH);
    assign o_head_valid = r_count != '0;
    assign push_ok      = i_push && o_push_ready;
    assign pop_ok       = i_pop && o_head_valid;
    assign o_head_op    = r_op[r_rd_ptr];
    assign o_head_col   = r_col[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_op[r_wr_ptr]  <= i_push_op;
            r_col[r_wr_ptr] <= i_push_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({push_ok, pop_ok})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: sv/bbe_back.sv
// ----------------------------------------------------------------------------
// bbe_back
// line buffer read-modify-write, 3x3 window, masked sums and rounded mean
// ----------------------------------------------------------------------------
`default_nettype none

module bbe_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_head_valid,
    input  bbe_pkg::t_op                 i_head_op,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_head_col,
    output logic                         o_pop,
    bbe_blur_if.source                   o_blur
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int PIX_W  = bbe_pkg::PIXEL_W;
    localparam int SUM_W  = 12;
    localparam int CNT_W  = 4;
    localparam int X_W    = SUM_W + 1;
    localparam int PROD_W = 27;
    localparam logic [14:0] RECIP3 = 15'd21846;
    localparam logic [14:0] RECIP9 = 15'd7282;

    function automatic logic [7:0] f_mean(input logic [X_W-1:0] x,
                                          input logic [CNT_W-1:0] cnt);
        logic [PROD_W-1:0] prod;
        logic [7:0]        q;
        prod = '0;
        q    = '0;
        case (cnt)
            4'd1: q = x[8:1];
            4'd2: q = x[9:2];
            4'd4: q = x[10:3];
            4'd3: begin
                prod = PROD_W'(x[X_W-1:1]) * PROD_W'(RECIP3);
                q    = prod[23:16];
            end
            4'd6: begin
                prod = PROD_W'(x[X_W-1:2]) * PROD_W'(RECIP3);
                q    = prod[23:16];
            end
            4'd9: begin
                prod = PROD_W'(x[X_W-1:1]) * PROD_W'(RECIP9);
                q    = prod[23:16];
            end
            default: q = x[8:1];
        endcase
        return q;
    endfunction

    logic adv;

    // line memory: upper line in the high half, middle line in the low half
    logic [2*PIX_W-1:0] r_line [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd;
    logic               r_byp;
    logic [2*PIX_W-1:0] r_byp_data;
    logic [2*PIX_W-1:0] line_eff;
    logic [2*PIX_W-1:0] wr_data;

    logic               r_s1_valid;
    bbe_pkg::t_op       r_s1_op;
    logic [COL_W-1:0]   r_s1_col;

    bbe_pkg::t_pixel    r_win [3][3];

    logic               r_s2_valid;
    logic [2:0]         r_s2_use_row;
    logic [2:0]         r_s2_use_col;
    logic               r_s2_eof;
    logic [SUM_W-1:0]   s2_sum [3];
    logic [CNT_W-1:0]   s2_cnt;

    logic               r_s3_valid;
    logic [SUM_W-1:0]   r_s3_sum [3];
    logic [CNT_W-1:0]   r_s3_count;
    logic               r_s3_eof;
    logic [7:0]         s3_mean [3];

    logic               r_out_valid;
    logic [7:0]         r_out_red;
    logic [7:0]         r_out_green;
    logic [7:0]         r_out_blue;
    logic               r_out_eof;

    assign adv   = !r_out_valid || o_blur.ready;
    assign o_pop = adv && i_head_valid;

    assign line_eff = r_byp ? r_byp_data : r_rd;
    assign wr_data  = {line_eff[PIX_W-1:0], r_s1_op.pix};

    always_ff @(posedge i_clk) begin
        if (adv && r_s1_valid) begin
            r_line[r_s1_col] <= wr_data;
        end
        if (o_pop) begin
            r_rd <= r_line[i_head_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_byp      <= r_s1_valid && (r_s1_col == i_head_col);
            r_byp_data <= wr_data;
        end
        if (adv) begin
            r_s1_op      <= i_head_op;
            r_s1_col     <= i_head_col;
            r_s2_use_row <= r_s1_op.use_row;
            r_s2_use_col <= r_s1_op.use_col;
            r_s2_eof     <= r_s1_op.eof;
            r_s3_sum     <= s2_sum;
            r_s3_count   <= s2_cnt;
            r_s3_eof     <= r_s2_eof;
            r_out_red    <= s3_mean[0];
            r_out_green  <= s3_mean[1];
            r_out_blue   <= s3_mean[2];
            r_out_eof    <= r_s3_eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (adv && r_s1_valid) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= line_eff[2*PIX_W-1:PIX_W];
            r_win[1][2] <= line_eff[PIX_W-1:0];
            r_win[2][2] <= r_s1_op.pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= i_head_valid;
            r_s2_valid  <= r_s1_valid && r_s1_op.primed;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    always_comb begin
        s2_cnt = '0;
        for (int k = 0; k < 3; k++) begin
            s2_sum[k] = '0;
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (r_s2_use_row[r] && r_s2_use_col[c]) begin
                    s2_cnt    = s2_cnt + CNT_W'(1);
                    s2_sum[0] = s2_sum[0] + SUM_W'(r_win[r][c][23:16]);
                    s2_sum[1] = s2_sum[1] + SUM_W'(r_win[r][c][15:8]);
                    s2_sum[2] = s2_sum[2] + SUM_W'(r_win[r][c][7:0]);
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s3_mean[k] = f_mean({r_s3_sum[k], 1'b0} + X_W'(r_s3_count), r_s3_count);
        end
    end

    assign o_blur.valid        = r_out_valid;
    assign o_blur.out_red      = r_out_red;
    assign o_blur.out_green    = r_out_green;
    assign o_blur.out_blue     = r_out_blue;
    assign o_blur.end_of_frame = r_out_eof;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_s1_valid) && $stable(r_s2_valid) && $stable(r_s3_valid))
        else $error("back pipeline moved during stall");

    a_count_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_valid |-> (r_s3_count == 4'd1 || r_s3_count == 4'd2 || r_s3_count == 4'd3 ||
                        r_s3_count == 4'd4 || r_s3_count == 4'd6 || r_s3_count == 4'd9))
        else $error("neighbour count not a product of row and column counts");

    a_eof_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && r_s2_eof |-> !r_s2_use_row[2] && !r_s2_use_col[2])
        else $error("end of frame away from bottom right corner");

    a_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && r_s1_valid && (r_s1_col == i_head_col) |=> r_byp)
        else $error("missed line buffer bypass");

endmodule

`default_nettype wire

FILE: sv/box_blur_3x3_edge_normalized.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_normalized
// streaming 3x3 box blur of 24-bit rgb with edge-normalized rounded mean
// ----------------------------------------------------------------------------
// Takes one pixel per clock in raster order and, while the output is not
// stalled by a low ready, sustains one word per clock on both channels; the
// rate is set by the single line memory (MAX_WIDTH x 48 bits, upper and
// middle line side by side), read and written once per word with a bypass
// for back-to-back hits on one column. A word passes the front and a
// four-entry queue, then four back stages (read, window update, masked sum,
// rounded divide) before it shows on the output register. Each output
// belongs to the pixel width+1 words earlier; send width+1 drain words
// (action high) after the last pixel to flush the frame.
// The line memory is not cleared after reset. Any register write restarts
// the frame position; write registers only while the block is idle.
`default_nettype none

module box_blur_3x3_edge_normalized #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bbe_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [bbe_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [bbe_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    bbe_pix_if.sink                        i_pix,
    bbe_blur_if.source                     o_blur
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    bbe_pkg::t_cfg    cfg;
    logic             push;
    bbe_pkg::t_op     push_op;
    logic [COL_W-1:0] push_col;
    logic             push_ready;
    logic             pop;
    logic             head_valid;
    bbe_pkg::t_op     head_op;
    logic [COL_W-1:0] head_col;

    bbe_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bbe_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_pix        (i_pix),
        .i_push_ready (push_ready),
        .o_push       (push),
        .o_push_op    (push_op),
        .o_push_col   (push_col)
    );

    bbe_queue #(
        .COL_W (COL_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_op    (push_op),
        .i_push_col   (push_col),
        .o_push_ready (push_ready),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head_op    (head_op),
        .o_head_col   (head_col)
    );

    bbe_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head_op    (head_op),
        .i_head_col   (head_col),
        .o_pop        (pop),
        .o_blur       (o_blur)
    );

endmodule

`default_nettype wire
